[sv/omni_wheel_power_mixer_top_assert.svh]
// Assertion macros for the omni-wheel power mixer RTL.
`ifndef OMNI_WHEEL_POWER_MIXER_TOP_ASSERT_SVH
`define OMNI_WHEEL_POWER_MIXER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define OWPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("owpm assertion failed");
`define OWPM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("owpm reset assertion failed");
`else
`define OWPM_ASSERT(lbl, prop)
`define OWPM_ASSERT_RST(lbl, prop)
`endif
`endif

[sv/owpm_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and the quarter-wave sine table of the omni-wheel power mixer.
package owpm_pkg;

  localparam int WHEEL_COUNT      = 4;
  localparam int ANGLE_BITS       = 12;
  localparam int SINE_FRAC_BITS   = 15;

  localparam int SLOTS            = 4;
  localparam int FIELD_ANGLE_BITS = 12;
  localparam int LEVEL_BITS       = 8;
  localparam int PWM_BITS         = 8;
  localparam int WHEEL_FIELD_BITS = PWM_BITS + 1;
  localparam int IN_TDATA_BITS    = 24;
  localparam int OUT_TDATA_BITS   = 40;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int CFG_DATA_BITS    = 12;

  localparam int QUARTER_BITS     = ANGLE_BITS - 2;
  localparam int INDEX_BITS       = QUARTER_BITS + 1;
  localparam int BANK_BITS        = (QUARTER_BITS < 8) ? QUARTER_BITS : 8;
  localparam int BANK_SIZE        = 1 << BANK_BITS;
  localparam int NUM_BANKS        = 1 << (QUARTER_BITS - BANK_BITS);
  localparam int BANK_SEL_BITS    = (QUARTER_BITS > BANK_BITS) ? (QUARTER_BITS - BANK_BITS) : 1;
  localparam int NUM_BITS         = SINE_FRAC_BITS + LEVEL_BITS + 1;
  localparam int DEN_BITS         = SINE_FRAC_BITS + 1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [INDEX_BITS-1:0] QUARTER_FULL = INDEX_BITS'(1) << QUARTER_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WHEEL0 = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_WHEEL1 = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_WHEEL2 = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_WHEEL3 = CFG_INDEX_BITS'(3);

  typedef logic [ANGLE_BITS-1:0]       angle_t;
  typedef logic [FIELD_ANGLE_BITS-1:0] field_angle_t;
  typedef logic [SINE_FRAC_BITS-1:0]   sine_mag_t;
  typedef logic [LEVEL_BITS-1:0]       level_t;
  typedef logic [PWM_BITS-1:0]         pwm_t;
  typedef logic [NUM_BITS-1:0]         num_t;
  typedef logic [DEN_BITS-1:0]         den_t;
  typedef logic [INDEX_BITS-1:0]       sine_index_t;
  typedef logic [BANK_SEL_BITS-1:0]    bank_sel_t;
  typedef field_angle_t [SLOTS-1:0]    angle_set_t;

  typedef struct packed {
    logic adv;
    logic valid;
  } pipe_ctl_t;

  typedef struct packed {
    sine_mag_t [SLOTS-1:0] mag;
    logic [SLOTS-1:0]      neg;
    level_t                level;
  } sine_item_t;

  typedef struct packed {
    num_t [SLOTS-1:0] num;
    den_t             den;
    logic [SLOTS-1:0] neg;
    logic             zero;
  } div_item_t;

  typedef struct packed {
    pwm_t [SLOTS-1:0] pwm;
    logic [SLOTS-1:0] fwd;
  } result_t;

  typedef sine_mag_t [BANK_SIZE-1:0]  sine_bank_t;
  typedef sine_bank_t [NUM_BANKS-1:0] sine_rom_t;

  localparam angle_set_t WHEEL_RESET = {12'd3413, 12'd2731, 12'd1365, 12'd683};

  function automatic angle_t to_angle(input field_angle_t a);
    return angle_t'(a);
  endfunction

  // Taylor series through the x^17 term in Q2.30, rounded to the sine fraction width.
  function automatic sine_mag_t quarter_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint      sum;
    x    = (HALF_PI_Q30 * 64'(k)) >> QUARTER_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    v = (64'(sum) + (64'd1 << (29 - SINE_FRAC_BITS))) >> (30 - SINE_FRAC_BITS);
    if (v > ((64'd1 << SINE_FRAC_BITS) - 64'd1)) v = (64'd1 << SINE_FRAC_BITS) - 64'd1;
    return SINE_FRAC_BITS'(v);
  endfunction

  function automatic sine_rom_t build_rom();
    sine_rom_t rom;
    for (int b = 0; b < NUM_BANKS; b++) begin
      for (int e = 0; e < BANK_SIZE; e++) begin
        rom[b][e] = quarter_entry(b * BANK_SIZE + e);
      end
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM  = build_rom();
  localparam sine_mag_t SINE_PEAK = quarter_entry(1 << QUARTER_BITS);

endpackage

[sv/omni_wheel_power_mixer_top.sv]
`timescale 1ns / 1ps
// Top level of the omni-wheel power mixer: configuration registers, pipeline and stream ports.
//
// Each input transfer carries a heading and a drive level and produces exactly one result
// transfer with a PWM magnitude and a direction bit for each of four wheels. The block takes
// one transfer per clock while the skid entry is empty. From input transfer to out_tvalid
// the data passes four sine stages (angle difference, quarter-wave index, banked table
// read, bank select), a maximum stage, a numerator stage, eight divider stages that each
// resolve one quotient bit, and the output register. A skid entry behind the output
// register absorbs backpressure, so in_tready depends only on registered state. Wheel angle
// registers are written through the cfg port and apply to headings accepted after the write.
module omni_wheel_power_mixer_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [owpm_pkg::IN_TDATA_BITS-1:0]    in_tdata,   // heading[11:0], drive_level[19:12]
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [owpm_pkg::OUT_TDATA_BITS-1:0]   out_tdata,  // pwm0, fwd0, pwm1, fwd1, pwm2,
                                                            // fwd2, pwm3, fwd3 (9 bits each)
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [owpm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [owpm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  owpm_pkg::angle_set_t wheel_angle_r;
  owpm_pkg::pipe_ctl_t  sine_ctl;
  owpm_pkg::pipe_ctl_t  scale_ctl;
  owpm_pkg::pipe_ctl_t  div_ctl;
  owpm_pkg::sine_item_t sine_item;
  owpm_pkg::div_item_t  div_item;
  owpm_pkg::result_t    div_result;
  owpm_pkg::result_t    out_result;
  logic                 sine_valid;
  logic                 scale_valid;
  logic                 div_valid;
  logic                 pipe_adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_angle_r <= owpm_pkg::WHEEL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        owpm_pkg::REG_WHEEL0: wheel_angle_r[0] <= cfg_data;
        owpm_pkg::REG_WHEEL1: wheel_angle_r[1] <= cfg_data;
        owpm_pkg::REG_WHEEL2: wheel_angle_r[2] <= cfg_data;
        owpm_pkg::REG_WHEEL3: wheel_angle_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = pipe_adv;
  assign sine_ctl  = '{adv: pipe_adv, valid: in_tvalid};
  assign scale_ctl = '{adv: pipe_adv, valid: sine_valid};
  assign div_ctl   = '{adv: pipe_adv, valid: scale_valid};

  owpm_sine u_sine (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (sine_ctl),
    .heading   (in_tdata[owpm_pkg::FIELD_ANGLE_BITS-1:0]),
    .level     (in_tdata[owpm_pkg::FIELD_ANGLE_BITS +: owpm_pkg::LEVEL_BITS]),
    .angles    (wheel_angle_r),
    .valid_out (sine_valid),
    .item_out  (sine_item)
  );

  owpm_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (scale_ctl),
    .item_in   (sine_item),
    .valid_out (scale_valid),
    .item_out  (div_item)
  );

  owpm_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_in     (div_ctl),
    .item_in    (div_item),
    .valid_out  (div_valid),
    .result_out (div_result)
  );

  owpm_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (div_valid),
    .push_data  (div_result),
    .pipe_adv   (pipe_adv),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_result)
  );

  always_comb begin
    out_tdata = '0;
    for (int w = 0; w < owpm_pkg::SLOTS; w++) begin
      out_tdata[w*owpm_pkg::WHEEL_FIELD_BITS +: owpm_pkg::PWM_BITS] = out_result.pwm[w];
      out_tdata[w*owpm_pkg::WHEEL_FIELD_BITS + owpm_pkg::PWM_BITS]  = out_result.fwd[w];
    end
  end

endmodule

[sv/owpm_sine.sv]
`timescale 1ns / 1ps
// Four-stage sine pipeline: angle difference, quarter-wave index, banked table read, bank select.
module owpm_sine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  owpm_pkg::pipe_ctl_t   ctl_in,
  input  owpm_pkg::field_angle_t heading,
  input  owpm_pkg::level_t      level,
  input  owpm_pkg::angle_set_t  angles,
  output logic                  valid_out,
  output owpm_pkg::sine_item_t  item_out
);

  logic                                          s1_valid_r;
  owpm_pkg::angle_t [owpm_pkg::SLOTS-1:0]        s1_diff_r;
  owpm_pkg::angle_t [owpm_pkg::SLOTS-1:0]        s1_diff_nxt;
  owpm_pkg::level_t                              s1_level_r;

  logic                                          s2_valid_r;
  owpm_pkg::sine_index_t [owpm_pkg::SLOTS-1:0]   s2_index_r;
  owpm_pkg::sine_index_t [owpm_pkg::SLOTS-1:0]   s2_index_nxt;
  logic [owpm_pkg::SLOTS-1:0]                    s2_neg_r;
  logic [owpm_pkg::SLOTS-1:0]                    s2_neg_nxt;
  owpm_pkg::level_t                              s2_level_r;

  logic                                          s3_valid_r;
  owpm_pkg::sine_mag_t [owpm_pkg::NUM_BANKS-1:0] s3_bank_r   [owpm_pkg::SLOTS];
  owpm_pkg::sine_mag_t [owpm_pkg::NUM_BANKS-1:0] s3_bank_nxt [owpm_pkg::SLOTS];
  owpm_pkg::bank_sel_t [owpm_pkg::SLOTS-1:0]     s3_sel_r;
  owpm_pkg::bank_sel_t [owpm_pkg::SLOTS-1:0]     s3_sel_nxt;
  logic [owpm_pkg::SLOTS-1:0]                    s3_peak_r;
  logic [owpm_pkg::SLOTS-1:0]                    s3_neg_r;
  owpm_pkg::level_t                              s3_level_r;

  logic                                          s4_valid_r;
  owpm_pkg::sine_mag_t [owpm_pkg::SLOTS-1:0]     s4_mag_r;
  owpm_pkg::sine_mag_t [owpm_pkg::SLOTS-1:0]     s4_mag_nxt;
  logic [owpm_pkg::SLOTS-1:0]                    s4_neg_r;
  owpm_pkg::level_t                              s4_level_r;

  // Wheels beyond the configured count see a zero angle, which yields a zero sine.
  always_comb begin
    for (int w = 0; w < owpm_pkg::SLOTS; w++) begin
      if (w < owpm_pkg::WHEEL_COUNT) begin
        s1_diff_nxt[w] = owpm_pkg::to_angle(heading) - owpm_pkg::to_angle(angles[w]);
      end else begin
        s1_diff_nxt[w] = '0;
      end
    end
  end

  always_comb begin
    for (int w = 0; w < owpm_pkg::SLOTS; w++) begin
      s2_neg_nxt[w] = s1_diff_r[w][owpm_pkg::ANGLE_BITS-1];
      if (s1_diff_r[w][owpm_pkg::ANGLE_BITS-2]) begin
        s2_index_nxt[w] = owpm_pkg::QUARTER_FULL -
                          {1'b0, s1_diff_r[w][owpm_pkg::QUARTER_BITS-1:0]};
      end else begin
        s2_index_nxt[w] = {1'b0, s1_diff_r[w][owpm_pkg::QUARTER_BITS-1:0]};
      end
    end
  end

  always_comb begin
    for (int w = 0; w < owpm_pkg::SLOTS; w++) begin
      s3_sel_nxt[w] = owpm_pkg::bank_sel_t'(
          s2_index_r[w][owpm_pkg::QUARTER_BITS-1:0] >> owpm_pkg::BANK_BITS);
      for (int b = 0; b < owpm_pkg::NUM_BANKS; b++) begin
        s3_bank_nxt[w][b] = owpm_pkg::SINE_ROM[b][s2_index_r[w][owpm_pkg::BANK_BITS-1:0]];
      end
    end
  end

  always_comb begin
    for (int w = 0; w < owpm_pkg::SLOTS; w++) begin
      s4_mag_nxt[w] = '0;
      for (int b = 0; b < owpm_pkg::NUM_BANKS; b++) begin
        if (s3_sel_r[w] == owpm_pkg::bank_sel_t'(b)) s4_mag_nxt[w] = s3_bank_r[w][b];
      end
      if (s3_peak_r[w]) s4_mag_nxt[w] = owpm_pkg::SINE_PEAK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (ctl_in.adv) begin
      s1_valid_r <= ctl_in.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.adv) begin
      s1_diff_r  <= s1_diff_nxt;
      s1_level_r <= level;
      s2_index_r <= s2_index_nxt;
      s2_neg_r   <= s2_neg_nxt;
      s2_level_r <= s1_level_r;
      s3_bank_r  <= s3_bank_nxt;
      s3_sel_r   <= s3_sel_nxt;
      for (int w = 0; w < owpm_pkg::SLOTS; w++) begin
        s3_peak_r[w] <= s2_index_r[w][owpm_pkg::QUARTER_BITS];
      end
      s3_neg_r   <= s2_neg_r;
      s3_level_r <= s2_level_r;
      s4_mag_r   <= s4_mag_nxt;
      s4_neg_r   <= s3_neg_r;
      s4_level_r <= s3_level_r;
    end
  end

  assign valid_out      = s4_valid_r;
  assign item_out.mag   = s4_mag_r;
  assign item_out.neg   = s4_neg_r;
  assign item_out.level = s4_level_r;

endmodule

[sv/owpm_scale.sv]
`timescale 1ns / 1ps
// Two-stage scaling front end: largest sine magnitude, then numerator and divisor setup.
module owpm_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  owpm_pkg::pipe_ctl_t  ctl_in,
  input  owpm_pkg::sine_item_t item_in,
  output logic                 valid_out,
  output owpm_pkg::div_item_t  item_out
);

  logic                 s5_valid_r;
  owpm_pkg::sine_item_t s5_item_r;
  owpm_pkg::sine_mag_t  s5_max_r;
  owpm_pkg::sine_mag_t  s5_max_nxt;
  owpm_pkg::sine_mag_t  max01;
  owpm_pkg::sine_mag_t  max23;

  logic                 s6_valid_r;
  owpm_pkg::div_item_t  s6_item_r;
  owpm_pkg::div_item_t  s6_item_nxt;
  logic [owpm_pkg::SINE_FRAC_BITS+owpm_pkg::LEVEL_BITS-1:0] prod [owpm_pkg::SLOTS];

  always_comb begin
    max01 = (item_in.mag[0] > item_in.mag[1]) ? item_in.mag[0] : item_in.mag[1];
    max23 = (item_in.mag[2] > item_in.mag[3]) ? item_in.mag[2] : item_in.mag[3];
    s5_max_nxt = (max01 > max23) ? max01 : max23;
  end

  always_comb begin
    for (int w = 0; w < owpm_pkg::SLOTS; w++) begin
      prod[w] = s5_item_r.mag[w] * s5_item_r.level;
      s6_item_nxt.num[w] = {prod[w], 1'b0} + owpm_pkg::num_t'(s5_max_r);
    end
    s6_item_nxt.den  = {s5_max_r, 1'b0};
    s6_item_nxt.neg  = s5_item_r.neg;
    s6_item_nxt.zero = (s5_item_r.level == '0) || (s5_max_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
    end else if (ctl_in.adv) begin
      s5_valid_r <= ctl_in.valid;
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.adv) begin
      s5_item_r <= item_in;
      s5_max_r  <= s5_max_nxt;
      s6_item_r <= s6_item_nxt;
    end
  end

  assign valid_out = s6_valid_r;
  assign item_out  = s6_item_r;

endmodule

[sv/owpm_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage for all wheels, plus result forming.
module owpm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  owpm_pkg::pipe_ctl_t ctl_in,
  input  owpm_pkg::div_item_t item_in,
  output logic                valid_out,
  output owpm_pkg::result_t   result_out
);

  localparam int LAST = owpm_pkg::PWM_BITS - 1;

  logic                                     valid_r [owpm_pkg::PWM_BITS];
  owpm_pkg::num_t [owpm_pkg::SLOTS-1:0]     rem_r   [owpm_pkg::PWM_BITS];
  owpm_pkg::pwm_t [owpm_pkg::SLOTS-1:0]     quo_r   [owpm_pkg::PWM_BITS];
  owpm_pkg::den_t                           den_r   [owpm_pkg::PWM_BITS];
  logic [owpm_pkg::SLOTS-1:0]               neg_r   [owpm_pkg::PWM_BITS];
  logic                                     zero_r  [owpm_pkg::PWM_BITS];

  for (genvar st = 0; st < owpm_pkg::PWM_BITS; st++) begin : g_stage
    logic                                 valid_in;
    owpm_pkg::num_t [owpm_pkg::SLOTS-1:0] rem_in;
    owpm_pkg::pwm_t [owpm_pkg::SLOTS-1:0] quo_in;
    owpm_pkg::den_t                       den_in;
    logic [owpm_pkg::SLOTS-1:0]           neg_in;
    logic                                 zero_in;
    owpm_pkg::num_t                       trial;
    owpm_pkg::num_t [owpm_pkg::SLOTS-1:0] rem_nxt;
    owpm_pkg::pwm_t [owpm_pkg::SLOTS-1:0] quo_nxt;

    if (st == 0) begin : g_first
      assign valid_in = ctl_in.valid;
      assign rem_in   = item_in.num;
      assign quo_in   = '0;
      assign den_in   = item_in.den;
      assign neg_in   = item_in.neg;
      assign zero_in  = item_in.zero;
    end else begin : g_next
      assign valid_in = valid_r[st-1];
      assign rem_in   = rem_r[st-1];
      assign quo_in   = quo_r[st-1];
      assign den_in   = den_r[st-1];
      assign neg_in   = neg_r[st-1];
      assign zero_in  = zero_r[st-1];
    end

    always_comb begin
      trial = owpm_pkg::num_t'(den_in) << (LAST - st);
      for (int w = 0; w < owpm_pkg::SLOTS; w++) begin
        if (rem_in[w] >= trial) begin
          rem_nxt[w] = rem_in[w] - trial;
          quo_nxt[w] = quo_in[w] | (owpm_pkg::pwm_t'(1) << (LAST - st));
        end else begin
          rem_nxt[w] = rem_in[w];
          quo_nxt[w] = quo_in[w];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[st] <= 1'b0;
      end else if (ctl_in.adv) begin
        valid_r[st] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_in.adv) begin
        rem_r[st]  <= rem_nxt;
        quo_r[st]  <= quo_nxt;
        den_r[st]  <= den_in;
        neg_r[st]  <= neg_in;
        zero_r[st] <= zero_in;
      end
    end
  end

  // A negative sine that rounds to zero drives forward.
  always_comb begin
    for (int w = 0; w < owpm_pkg::SLOTS; w++) begin
      if (zero_r[LAST]) begin
        result_out.pwm[w] = '0;
        result_out.fwd[w] = 1'b1;
      end else begin
        result_out.pwm[w] = quo_r[LAST][w];
        result_out.fwd[w] = !(neg_r[LAST][w] && (quo_r[LAST][w] != '0));
      end
    end
  end

  assign valid_out = valid_r[LAST];

endmodule

[sv/owpm_outbuf.sv]
`timescale 1ns / 1ps
// Output register with a skid entry that decouples the result handshake from the pipeline.
`include "omni_wheel_power_mixer_top_assert.svh"
module owpm_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  owpm_pkg::result_t push_data,
  output logic              pipe_adv,
  output logic              out_valid,
  input  logic              out_ready,
  output owpm_pkg::result_t out_data
);

  logic              out_valid_r;
  logic              out_valid_nxt;
  owpm_pkg::result_t out_data_r;
  owpm_pkg::result_t out_data_nxt;
  logic              skid_valid_r;
  logic              skid_valid_nxt;
  owpm_pkg::result_t skid_data_r;
  owpm_pkg::result_t skid_data_nxt;
  logic              push;

  assign pipe_adv = !skid_valid_r;
  assign push     = push_valid && pipe_adv;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `OWPM_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r)
  `OWPM_ASSERT(a_stall_fills_skid, (out_valid_r && !out_ready && push) |=> skid_valid_r)
  `OWPM_ASSERT_RST(a_reset_empties, !rst_n |=> (!out_valid_r && !skid_valid_r))

endmodule

[test/omni_wheel_power_mixer_top_test.sv]
`timescale 1ns / 1ps
// Self-checking stream testbench for the omni-wheel power mixer with its own wheel-mixing predictor.
module omni_wheel_power_mixer_top_test;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_GAP      = 20;
  localparam int PRINT_LIMIT    = 40;
  localparam int HOLD_CYCLES    = 200;

  typedef logic [owpm_pkg::CFG_INDEX_BITS-1:0] reg_index_t;
  typedef logic [$clog2(owpm_pkg::SLOTS)-1:0]  slot_t;

  typedef struct packed {
    owpm_pkg::angle_t                     heading;
    owpm_pkg::level_t                     level;
    owpm_pkg::pwm_t [owpm_pkg::SLOTS-1:0] pwm;
    logic [owpm_pkg::SLOTS-1:0]           fwd;
  } drive_cmd_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_tvalid;
  logic                                in_tready;
  logic [owpm_pkg::IN_TDATA_BITS-1:0]  in_tdata;   // heading[11:0], drive_level[19:12]
  logic                                out_tvalid;
  logic                                out_tready;
  logic [owpm_pkg::OUT_TDATA_BITS-1:0] out_tdata;  // pwm0, fwd0, pwm1, fwd1, pwm2, fwd2, pwm3, fwd3
  logic                                cfg_valid;
  logic                                cfg_ready;
  reg_index_t                          cfg_index;
  logic [owpm_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  owpm_pkg::field_angle_t mount_angle [owpm_pkg::SLOTS];
  drive_cmd_t             pending_drive [$];
  int                     send_idle_pct;
  int                     recv_idle_pct;
  int                     hold_left;
  int                     mismatch_count;
  int                     commands_accepted;
  int                     results_checked;
  int                     angle_writes;
  int                     quiet_cycles;

  omni_wheel_power_mixer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Quarter-wave sine entry from a Taylor series in Q2.30.
  function automatic longint unsigned sine_table_entry(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned rounded;
    longint          acc;
    x    = (owpm_pkg::HALF_PI_Q30 * 64'(k)) >> owpm_pkg::QUARTER_BITS;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    rounded = (64'(acc) + (64'd1 << (29 - owpm_pkg::SINE_FRAC_BITS))) >>
              (30 - owpm_pkg::SINE_FRAC_BITS);
    if (rounded > (64'd1 << owpm_pkg::SINE_FRAC_BITS) - 64'd1)
      rounded = (64'd1 << owpm_pkg::SINE_FRAC_BITS) - 64'd1;
    return rounded;
  endfunction

  function automatic longint wheel_sine(input owpm_pkg::angle_t a);
    logic [1:0]        quadrant;
    int unsigned       offset;
    longint unsigned   entry;
    quadrant = a[owpm_pkg::ANGLE_BITS-1 -: 2];
    offset   = 32'(a[owpm_pkg::QUARTER_BITS-1:0]);
    entry    = sine_table_entry(quadrant[0] ? (1 << owpm_pkg::QUARTER_BITS) - offset
                                            : offset);
    return quadrant[1] ? -longint'(entry) : longint'(entry);
  endfunction

  function automatic drive_cmd_t mix_command(input owpm_pkg::angle_t heading,
                                             input owpm_pkg::level_t level);
    drive_cmd_t       cmd;
    longint           s [owpm_pkg::SLOTS];
    longint unsigned  mag [owpm_pkg::SLOTS];
    longint unsigned  peak;
    longint unsigned  scaled;
    owpm_pkg::angle_t diff;
    cmd.heading = heading;
    cmd.level   = level;
    peak        = 0;
    for (int i = 0; i < owpm_pkg::SLOTS; i++) begin
      s[i]   = 0;
      mag[i] = 0;
      if (i < owpm_pkg::WHEEL_COUNT) begin
        diff   = heading - owpm_pkg::angle_t'(mount_angle[i]);
        s[i]   = wheel_sine(diff);
        mag[i] = (s[i] < 0) ? -s[i] : s[i];
        if (mag[i] > peak) peak = mag[i];
      end
    end
    for (int i = 0; i < owpm_pkg::SLOTS; i++) begin
      cmd.pwm[i] = '0;
      cmd.fwd[i] = 1'b1;
      if (i < owpm_pkg::WHEEL_COUNT && level != 0 && peak != 0) begin
        scaled     = (64'd2 * mag[i] * 64'(level) + peak) / (64'd2 * peak);
        cmd.pwm[i] = owpm_pkg::pwm_t'(scaled);
        cmd.fwd[i] = !(s[i] < 0 && scaled != 0);
      end
    end
    return cmd;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < owpm_pkg::SLOTS; i++) mount_angle[i] <= owpm_pkg::WHEEL_RESET[i];
    end else if (cfg_valid && cfg_ready && cfg_index < owpm_pkg::SLOTS) begin
      mount_angle[slot_t'(cfg_index)] <= cfg_data;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      pending_drive.push_back(mix_command(
          in_tdata[owpm_pkg::ANGLE_BITS-1:0],
          in_tdata[owpm_pkg::FIELD_ANGLE_BITS +: owpm_pkg::LEVEL_BITS]));
      commands_accepted++;
    end
  end

  always @(posedge clk) begin : check_results
    drive_cmd_t     want;
    owpm_pkg::pwm_t got_pwm;
    logic           got_fwd;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_drive.size() == 0) begin
        report_mismatch("result transfer with no command outstanding");
      end else begin
        want = pending_drive.pop_front();
        results_checked++;
        for (int w = 0; w < owpm_pkg::SLOTS; w++) begin
          got_pwm = out_tdata[w * owpm_pkg::WHEEL_FIELD_BITS +: owpm_pkg::PWM_BITS];
          got_fwd = out_tdata[w * owpm_pkg::WHEEL_FIELD_BITS + owpm_pkg::PWM_BITS];
          if (got_pwm !== want.pwm[w])
            report_mismatch($sformatf("heading %0d level %0d wheel %0d pwm %0d, want %0d",
                                      want.heading, want.level, w, got_pwm, want.pwm[w]));
          if (got_fwd !== want.fwd[w])
            report_mismatch($sformatf("heading %0d level %0d wheel %0d fwd %0b, want %0b",
                                      want.heading, want.level, w, got_fwd, want.fwd[w]));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d cycles without a transfer.", quiet_cycles);
      $display("omni_wheel_power_mixer_top: mismatch");
      $finish;
    end
  end

  // The receiver counts down a hold-off on its own and otherwise stalls at random.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_command(input owpm_pkg::angle_t heading, input owpm_pkg::level_t level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = owpm_pkg::IN_TDATA_BITS'({level, heading});
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_random_command();
    owpm_pkg::angle_t heading;
    owpm_pkg::level_t level;
    slot_t            slot;
    int               pick;
    pick = $urandom_range(7);
    slot = slot_t'($urandom_range(owpm_pkg::SLOTS - 1));
    if (pick == 0)
      heading = owpm_pkg::angle_t'(mount_angle[slot] +
                                   ($urandom_range(3) << owpm_pkg::QUARTER_BITS) +
                                   $urandom_range(2) - 1);
    else
      heading = owpm_pkg::angle_t'($urandom);
    pick = $urandom_range(15);
    if (pick == 0)      level = '0;
    else if (pick == 1) level = '1;
    else if (pick == 2) level = owpm_pkg::level_t'($urandom_range(4, 1));
    else                level = owpm_pkg::level_t'($urandom);
    send_command(heading, level);
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    @(posedge clk);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    @(negedge clk);
  endtask

  task automatic write_wheel_angle(input reg_index_t idx, input owpm_pkg::field_angle_t value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    angle_writes++;
  endtask

  task automatic load_mount_angles(input owpm_pkg::field_angle_t a0,
                                   input owpm_pkg::field_angle_t a1,
                                   input owpm_pkg::field_angle_t a2,
                                   input owpm_pkg::field_angle_t a3);
    wait_idle();
    write_wheel_angle(owpm_pkg::REG_WHEEL0, a0);
    write_wheel_angle(owpm_pkg::REG_WHEEL1, a1);
    write_wheel_angle(owpm_pkg::REG_WHEEL2, a2);
    write_wheel_angle(owpm_pkg::REG_WHEEL3, a3);
  endtask

  task automatic load_random_angles();
    load_mount_angles(owpm_pkg::field_angle_t'($urandom), owpm_pkg::field_angle_t'($urandom),
                      owpm_pkg::field_angle_t'($urandom), owpm_pkg::field_angle_t'($urandom));
  endtask

  task automatic test_reset_angles();
    send_command(owpm_pkg::angle_t'(0), owpm_pkg::level_t'(0));
    send_command(owpm_pkg::angle_t'(0), owpm_pkg::level_t'(255));
    send_command(owpm_pkg::angle_t'(4095), owpm_pkg::level_t'(255));
    send_command(owpm_pkg::angle_t'(2048), owpm_pkg::level_t'(1));
    send_command(owpm_pkg::angle_t'(683), owpm_pkg::level_t'(128));
    send_command(owpm_pkg::angle_t'(4095), owpm_pkg::level_t'(0));
    wait_idle();
  endtask

  task automatic test_exact_quadrants();
    load_mount_angles(12'd0, 12'd1024, 12'd2048, 12'd3072);
    send_command(owpm_pkg::angle_t'(0), owpm_pkg::level_t'(255));
    send_command(owpm_pkg::angle_t'(1024), owpm_pkg::level_t'(255));
    send_command(owpm_pkg::angle_t'(2048), owpm_pkg::level_t'(128));
    send_command(owpm_pkg::angle_t'(3072), owpm_pkg::level_t'(1));
    // A tiny negative sine on wheel 0 rounds to zero and must read forward.
    send_command(owpm_pkg::angle_t'(4095), owpm_pkg::level_t'(1));
    send_command(owpm_pkg::angle_t'(1), owpm_pkg::level_t'(2));
    send_command(owpm_pkg::angle_t'(512), owpm_pkg::level_t'(255));
    wait_idle();
  endtask

  task automatic test_all_sines_zero();
    load_mount_angles(12'd0, 12'd2048, 12'd0, 12'd2048);
    send_command(owpm_pkg::angle_t'(0), owpm_pkg::level_t'(255));
    send_command(owpm_pkg::angle_t'(2048), owpm_pkg::level_t'(255));
    send_command(owpm_pkg::angle_t'(1), owpm_pkg::level_t'(255));
    wait_idle();
  endtask

  task automatic test_unmapped_registers();
    wait_idle();
    for (int n = 0; n < (1 << owpm_pkg::CFG_INDEX_BITS) - owpm_pkg::SLOTS; n++)
      write_wheel_angle(reg_index_t'(owpm_pkg::SLOTS + n), '1);
    send_command(owpm_pkg::angle_t'(1024), owpm_pkg::level_t'(200));
    send_command(owpm_pkg::angle_t'(3000), owpm_pkg::level_t'(77));
    wait_idle();
  endtask

  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) send_random_command();
    wait_idle();
  endtask

  task automatic test_backpressure_fill(input int count);
    wait_idle();
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    @(negedge clk);
    for (int n = 0; n < count; n++) send_random_command();
    wait_idle();
  endtask

  task automatic test_drain_pause(input int burst);
    for (int n = 0; n < burst; n++) send_random_command();
    wait_idle();
    for (int n = 0; n < burst; n++) send_random_command();
    wait_idle();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_tvalid         = 1'b0;
    in_tdata          = '0;
    cfg_valid         = 1'b0;
    cfg_index         = owpm_pkg::REG_WHEEL0;
    cfg_data          = '0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    hold_left         = 0;
    mismatch_count    = 0;
    commands_accepted = 0;
    results_checked   = 0;
    angle_writes      = 0;
    quiet_cycles      = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_idling(21, 51);
    test_reset_angles();
    test_exact_quadrants();
    test_all_sines_zero();
    test_unmapped_registers();
    load_random_angles();
    test_random_traffic(150);

    set_idling(51, 21);
    load_mount_angles('1, '1, '1, '1);
    test_random_traffic(75);
    load_mount_angles('0, '0, '0, '0);
    test_random_traffic(75);

    set_idling(0, 0);
    load_random_angles();
    test_random_traffic(150);
    test_backpressure_fill(60);
    test_drain_pause(10);

    wait_idle();
    $display("Run covered %0d commands and %0d checked results over %0d angle writes,",
             commands_accepted, results_checked, angle_writes);
    $display("including exact quadrants, all-zero sines, unmapped indexes and a full stall.");
    if (mismatch_count == 0) begin
      $display("omni_wheel_power_mixer_top: match");
    end else begin
      $display("omni_wheel_power_mixer_top: mismatch");
    end
    $finish;
  end

endmodule
